[rtl/core/rsi_pkg.sv]
// Shared constants, result codes and sideband types of the ray/sphere intersection unit.
package rsi_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    localparam int CW    = 32;            // coordinate width
    localparam int TW    = 31;            // radius and time width
    localparam int PW    = CW + 1;        // origin minus centre
    localparam int AW    = 64;            // a = dir.dir
    localparam int HW    = 66;            // h = dir.P, signed
    localparam int CCW   = 67;            // c = P.P - r^2, signed
    localparam int MW    = 66;            // magnitudes fed to the limb multipliers
    localparam int LIMB  = 22;
    localparam int NLIMB = MW / LIMB;
    localparam int PPW   = 2 * LIMB;
    localparam int ROWW  = PPW + LIMB * (NLIMB - 1);
    localparam int DSW   = 2 * MW;        // discriminant width
    localparam int RW    = DSW / 2;       // square root width
    localparam int NUMW  = RW + 2;        // root numerator, signed
    localparam int MAGW  = NUMW - 1;

    // Edges from the accepting edge to the edge that takes the result.
    localparam int LATENCY = 108;

    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_ENTER = 2'd1;
    localparam logic [1:0] HIT_LEAVE = 2'd2;

    localparam logic [TW-1:0] T_START_RST = TW'(1);

    typedef struct packed {
        logic          nohit;
        logic [HW-1:0] h;
        logic [AW-1:0] a;
        logic [TW-1:0] t_end;
    } t_sq_side;

    typedef struct packed {
        logic          nohit;
        logic          neg1;
        logic          neg2;
        logic [TW-1:0] t_end;
    } t_div_side;

endpackage

[rtl/core/rsi_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
module rsi_sqrt_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [rsi_pkg::DSW-1:0]       i_rad,
    input  rsi_pkg::t_sq_side             i_side,
    output logic                          o_valid,
    output logic [rsi_pkg::RW-1:0]        o_root,
    output rsi_pkg::t_sq_side             o_side
);

    localparam int DSW  = rsi_pkg::DSW;
    localparam int RW   = rsi_pkg::RW;
    localparam int REMW = RW + 1;

    logic                 r_v    [0:RW-1];
    logic [REMW-1:0]      r_rem  [0:RW-1];
    logic [RW-1:0]        r_root [0:RW-1];
    logic [DSW-1:0]       r_num  [0:RW-1];
    rsi_pkg::t_sq_side    r_side [0:RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic                 p_v;
        logic [REMW-1:0]      p_rem;
        logic [RW-1:0]        p_root;
        logic [DSW-1:0]       p_num;
        rsi_pkg::t_sq_side    p_side;
        logic [REMW+1:0]      remx;
        logic [REMW+1:0]      trial;
        logic                 take;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_num  = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_num  = r_num[k-1];
            assign p_side = r_side[k-1];
        end

        assign remx  = {p_rem, p_num[DSW-1 -: 2]};
        assign trial = {1'b0, p_root, 2'b01};
        assign take  = (remx >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= take ? REMW'(remx - trial) : REMW'(remx);
            r_root[k] <= {p_root[RW-2:0], take};
            r_num[k]  <= {p_num[DSW-3:0], 2'b00};
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

[rtl/core/rsi_div_pipe.sv]
// Pipelined restoring divider for both root times, one quotient bit per stage.
module rsi_div_pipe #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [rsi_pkg::MAGW-1:0]      i_num1,
    input  logic [rsi_pkg::MAGW-1:0]      i_num2,
    input  logic [rsi_pkg::AW-1:0]        i_den,
    input  rsi_pkg::t_div_side            i_side,
    output logic                          o_valid,
    output logic [rsi_pkg::TW-1:0]        o_time1,
    output logic [rsi_pkg::TW-1:0]        o_time2,
    output rsi_pkg::t_div_side            o_side
);

    localparam int QW  = rsi_pkg::TW;
    localparam int AW  = rsi_pkg::AW;
    localparam int NW  = rsi_pkg::MAGW + FRAC_BITS;
    localparam int RMW = AW + QW;
    localparam int SW  = (NW > RMW) ? NW : RMW;

    logic [SW-1:0] w_n1;
    logic [SW-1:0] w_n2;
    logic [SW-1:0] w_lim;

    logic                  r_v    [0:QW];
    logic                  r_sat1 [0:QW];
    logic                  r_sat2 [0:QW];
    logic [RMW-1:0]        r_rem1 [0:QW];
    logic [RMW-1:0]        r_rem2 [0:QW];
    logic [QW-1:0]         r_q1   [0:QW];
    logic [QW-1:0]         r_q2   [0:QW];
    logic [AW-1:0]         r_den  [0:QW];
    rsi_pkg::t_div_side    r_side [0:QW];

    assign w_n1  = SW'(i_num1) << FRAC_BITS;
    assign w_n2  = SW'(i_num2) << FRAC_BITS;
    assign w_lim = SW'(i_den) << QW;

    // First stage: a quotient of 2^31 or more saturates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat1[0] <= (w_n1 >= w_lim);
        r_sat2[0] <= (w_n2 >= w_lim);
        r_rem1[0] <= w_n1[RMW-1:0];
        r_rem2[0] <= w_n2[RMW-1:0];
        r_q1[0]   <= '0;
        r_q2[0]   <= '0;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [RMW-1:0] sub;
        logic           take1;
        logic           take2;

        assign sub   = RMW'(r_den[k-1]) << (QW - k);
        assign take1 = (r_rem1[k-1] >= sub);
        assign take2 = (r_rem2[k-1] >= sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sat1[k] <= r_sat1[k-1];
            r_sat2[k] <= r_sat2[k-1];
            r_rem1[k] <= take1 ? r_rem1[k-1] - sub : r_rem1[k-1];
            r_rem2[k] <= take2 ? r_rem2[k-1] - sub : r_rem2[k-1];
            r_q1[k]   <= {r_q1[k-1][QW-2:0], take1};
            r_q2[k]   <= {r_q2[k-1][QW-2:0], take2};
            r_den[k]  <= r_den[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_v[QW];
    assign o_time1 = r_sat1[QW] ? '1 : r_q1[QW];
    assign o_time2 = r_sat2[QW] ? '1 : r_q2[QW];
    assign o_side  = r_side[QW];

endmodule

[rtl/core/ray_sphere_intersect_unit.sv]
// Ray/sphere intersection unit: top level with the front-end arithmetic and hit selection.
// Pipeline: an item is carried through 8 set-up stages, 66 square-root stages, one root
// stage, 32 divider stages and the output register, which drives the result ports.
// Throughput: one item per cycle; busy is never raised and the receiver cannot stall.
// Reset clears the valid bits of every stage and sets t_start to one; data is not reset.
module ray_sphere_intersect_unit #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [rsi_pkg::CW-1:0]        i_origin_x,
    input  logic signed [rsi_pkg::CW-1:0]        i_origin_y,
    input  logic signed [rsi_pkg::CW-1:0]        i_origin_z,
    input  logic signed [rsi_pkg::CW-1:0]        i_dir_x,
    input  logic signed [rsi_pkg::CW-1:0]        i_dir_y,
    input  logic signed [rsi_pkg::CW-1:0]        i_dir_z,
    input  logic signed [rsi_pkg::CW-1:0]        i_center_x,
    input  logic signed [rsi_pkg::CW-1:0]        i_center_y,
    input  logic signed [rsi_pkg::CW-1:0]        i_center_z,
    input  logic [rsi_pkg::TW-1:0]               i_radius,
    input  logic [rsi_pkg::TW-1:0]               i_t_end,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rsi_pkg::TW-1:0]               i_cfg_t_start,
    output logic                                 o_result_strobe,
    output logic [1:0]                           o_hit_kind,
    output logic [rsi_pkg::TW-1:0]               o_hit_time
);

    localparam int CW    = rsi_pkg::CW;
    localparam int TW    = rsi_pkg::TW;
    localparam int PW    = rsi_pkg::PW;
    localparam int AW    = rsi_pkg::AW;
    localparam int HW    = rsi_pkg::HW;
    localparam int CCW   = rsi_pkg::CCW;
    localparam int MW    = rsi_pkg::MW;
    localparam int LIMB  = rsi_pkg::LIMB;
    localparam int NLIMB = rsi_pkg::NLIMB;
    localparam int PPW   = rsi_pkg::PPW;
    localparam int ROWW  = rsi_pkg::ROWW;
    localparam int DSW   = rsi_pkg::DSW;
    localparam int RW    = rsi_pkg::RW;
    localparam int NUMW  = rsi_pkg::NUMW;
    localparam int MAGW  = rsi_pkg::MAGW;

    function automatic logic [2*TW-1:0] i_radius_sq(input logic [TW-1:0] r);
        return r * r;
    endfunction

    // The pipeline never stalls, so a start is always taken, and so is a
    // configuration transfer.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic [TW-1:0] r_t_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_start <= rsi_pkg::T_START_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_t_start <= i_cfg_t_start;
        end
    end

    // Stage 1: relative origin P = origin - centre per axis.
    logic                   r_v1;
    logic signed [PW-1:0]   r_p [0:2];
    logic signed [CW-1:0]   r_d [0:2];
    logic [TW-1:0]          r_rad1;
    logic [TW-1:0]          r_tend1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0]  <= $signed({i_origin_x[CW-1], i_origin_x}) - $signed({i_center_x[CW-1], i_center_x});
        r_p[1]  <= $signed({i_origin_y[CW-1], i_origin_y}) - $signed({i_center_y[CW-1], i_center_y});
        r_p[2]  <= $signed({i_origin_z[CW-1], i_origin_z}) - $signed({i_center_z[CW-1], i_center_z});
        r_d[0]  <= i_dir_x;
        r_d[1]  <= i_dir_y;
        r_d[2]  <= i_dir_z;
        r_rad1  <= i_radius;
        r_tend1 <= i_t_end;
    end

    // Stage 2: the per-axis products and the squared radius.
    logic                       r_v2;
    logic [AW-1:0]              r_dd [0:2];
    logic signed [2*CW:0]       r_dp [0:2];
    logic signed [2*PW-1:0]     r_pp [0:2];
    logic [2*TW-1:0]            r_rr;
    logic [TW-1:0]              r_tend2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
        always_ff @(posedge i_clk) begin
            r_dd[ax] <= AW'(r_d[ax] * r_d[ax]);
            r_dp[ax] <= (2*CW+1)'(r_d[ax] * r_p[ax]);
            r_pp[ax] <= r_p[ax] * r_p[ax];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rr    <= i_radius_sq(r_rad1);
        r_tend2 <= r_tend1;
    end

    // Stage 3: a = dir.dir, h = dir.P and c = P.P - r^2.
    logic                   r_v3;
    logic [AW-1:0]          r_a3;
    logic signed [HW-1:0]   r_h3;
    logic signed [CCW-1:0]  r_c3;
    logic [TW-1:0]          r_tend3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a3    <= r_dd[0] + r_dd[1] + r_dd[2];
        r_h3    <= HW'(r_dp[0]) + HW'(r_dp[1]) + HW'(r_dp[2]);
        r_c3    <= CCW'(r_pp[0]) + CCW'(r_pp[1]) + CCW'(r_pp[2])
                   - $signed({{(CCW-2*TW){1'b0}}, r_rr});
        r_tend3 <= r_tend2;
    end

    // Stage 4: magnitudes for the wide products h*h and a*c.
    logic                  r_v4;
    logic [MW-1:0]         r_hm;
    logic [MW-1:0]         r_cm;
    logic [MW-1:0]         r_am;
    logic                  r_cneg4;
    rsi_pkg::t_sq_side     r_sd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hm        <= r_h3[HW-1] ? MW'(-r_h3) : MW'(r_h3);
        r_cm        <= r_c3[CCW-1] ? MW'(-r_c3) : MW'(r_c3);
        r_am        <= MW'(r_a3);
        r_cneg4     <= r_c3[CCW-1];
        r_sd4.nohit <= 1'b0;
        r_sd4.h     <= r_h3;
        r_sd4.a     <= r_a3;
        r_sd4.t_end <= r_tend3;
    end

    // Stage 5: limb products, each well inside one hard multiplier.
    logic                  r_v5;
    logic [PPW-1:0]        r_hpp [0:NLIMB-1][0:NLIMB-1];
    logic [PPW-1:0]        r_acp [0:NLIMB-1][0:NLIMB-1];
    logic                  r_cneg5;
    rsi_pkg::t_sq_side     r_sd5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
    end

    for (genvar li = 0; li < NLIMB; li++) begin : g_lrow
        for (genvar lj = 0; lj < NLIMB; lj++) begin : g_lcol
            always_ff @(posedge i_clk) begin
                r_hpp[li][lj] <= r_hm[LIMB*li +: LIMB] * r_hm[LIMB*lj +: LIMB];
                r_acp[li][lj] <= r_am[LIMB*li +: LIMB] * r_cm[LIMB*lj +: LIMB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cneg5 <= r_cneg4;
        r_sd5   <= r_sd4;
    end

    // Stage 6: one sum per row of limb products.
    logic                  r_v6;
    logic [ROWW-1:0]       r_hrow [0:NLIMB-1];
    logic [ROWW-1:0]       r_acrow [0:NLIMB-1];
    logic                  r_cneg6;
    rsi_pkg::t_sq_side     r_sd6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
    end

    for (genvar li = 0; li < NLIMB; li++) begin : g_rsum
        logic [ROWW-1:0] hsum;
        logic [ROWW-1:0] acsum;

        always_comb begin
            hsum  = '0;
            acsum = '0;
            for (int j = 0; j < NLIMB; j++) begin
                hsum  = hsum + (ROWW'(r_hpp[li][j]) << (LIMB * j));
                acsum = acsum + (ROWW'(r_acp[li][j]) << (LIMB * j));
            end
        end

        always_ff @(posedge i_clk) begin
            r_hrow[li]  <= hsum;
            r_acrow[li] <= acsum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cneg6 <= r_cneg5;
        r_sd6   <= r_sd5;
    end

    // Stage 7: the full products h*h and a*|c|.
    logic                  r_v7;
    logic [DSW-1:0]        r_hh;
    logic [DSW-1:0]        r_ac;
    logic                  r_cneg7;
    rsi_pkg::t_sq_side     r_sd7;
    logic [DSW-1:0]        hh_sum;
    logic [DSW-1:0]        ac_sum;

    always_comb begin
        hh_sum = '0;
        ac_sum = '0;
        for (int i = 0; i < NLIMB; i++) begin
            hh_sum = hh_sum + (DSW'(r_hrow[i]) << (LIMB * i));
            ac_sum = ac_sum + (DSW'(r_acrow[i]) << (LIMB * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hh    <= hh_sum;
        r_ac    <= ac_sum;
        r_cneg7 <= r_cneg6;
        r_sd7   <= r_sd6;
    end

    // Stage 8: discriminant h*h - a*c. A zero direction, a miss or a tangent
    // marks the item as having no hit; the root pipeline still carries it.
    logic                  r_v8;
    logic [DSW-1:0]        r_disc;
    rsi_pkg::t_sq_side     r_sd8;
    logic [DSW:0]          disc;

    assign disc = r_cneg7 ? ({1'b0, r_hh} + {1'b0, r_ac}) : ({1'b0, r_hh} - {1'b0, r_ac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        r_disc      <= disc[DSW-1:0];
        r_sd8.h     <= r_sd7.h;
        r_sd8.a     <= r_sd7.a;
        r_sd8.t_end <= r_sd7.t_end;
        r_sd8.nohit <= (r_sd7.a == '0) || disc[DSW] || (disc == '0);
    end

    // Square root of the discriminant.
    logic                  sq_valid;
    logic [RW-1:0]         sq_root;
    rsi_pkg::t_sq_side     sq_side;

    rsi_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v8),
        .i_rad   (r_disc),
        .i_side  (r_sd8),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Root numerators: near -h - s and far -h + s. A negative numerator
    // gives a negative time, which is never a hit, so only its sign matters.
    logic                  r_v9;
    logic [MAGW-1:0]       r_n1;
    logic [MAGW-1:0]       r_n2;
    logic [AW-1:0]         r_a9;
    rsi_pkg::t_div_side    r_ds9;
    logic [NUMW-1:0]       hx;
    logic [NUMW-1:0]       sx;
    logic [NUMW-1:0]       n1;
    logic [NUMW-1:0]       n2;

    assign hx = {{(NUMW-HW){sq_side.h[HW-1]}}, sq_side.h};
    assign sx = {{(NUMW-RW){1'b0}}, sq_root};
    assign n1 = '0 - hx - sx;
    assign n2 = sx - hx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else begin
            r_v9 <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n1        <= n1[MAGW-1:0];
        r_n2        <= n2[MAGW-1:0];
        r_a9        <= sq_side.a;
        r_ds9.nohit <= sq_side.nohit;
        r_ds9.neg1  <= n1[NUMW-1];
        r_ds9.neg2  <= n2[NUMW-1];
        r_ds9.t_end <= sq_side.t_end;
    end

    // Root times floor(n * 2^FRAC_BITS / a), saturated.
    logic                  dv_valid;
    logic [TW-1:0]         dv_t1;
    logic [TW-1:0]         dv_t2;
    rsi_pkg::t_div_side    dv_side;

    rsi_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v9),
        .i_num1  (r_n1),
        .i_num2  (r_n2),
        .i_den   (r_a9),
        .i_side  (r_ds9),
        .o_valid (dv_valid),
        .o_time1 (dv_t1),
        .o_time2 (dv_t2),
        .o_side  (dv_side)
    );

    // Output stage: the near root wins when it lies inside the window, otherwise the far root.
    // The user must keep t_start stable while items are in flight; the block does not enforce it.
    logic                  ok1;
    logic                  ok2;
    logic                  r_strobe;
    logic [1:0]            r_kind;
    logic [TW-1:0]         r_time;
    logic [1:0]            n_kind;
    logic [TW-1:0]         n_time;

    assign ok1 = !dv_side.neg1 && (dv_t1 >= r_t_start) && (dv_t1 <= dv_side.t_end);
    assign ok2 = !dv_side.neg2 && (dv_t2 >= r_t_start) && (dv_t2 <= dv_side.t_end);

    always_comb begin
        n_kind = rsi_pkg::HIT_NONE;
        n_time = '0;
        if (!dv_side.nohit) begin
            if (ok1) begin
                n_kind = rsi_pkg::HIT_ENTER;
                n_time = dv_t1;
            end else if (ok2) begin
                n_kind = rsi_pkg::HIT_LEAVE;
                n_time = dv_t2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_time <= n_time;
    end

    assign o_result_strobe = r_strobe;
    assign o_hit_kind      = r_kind;
    assign o_hit_time      = r_time;

endmodule

[rtl/core/rsi_checker.sv]
// Port-level checker of the ray/sphere intersection unit and its bind.
module rsi_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [rsi_pkg::CW-1:0]        i_origin_x,
    input logic [rsi_pkg::CW-1:0]        i_origin_y,
    input logic [rsi_pkg::CW-1:0]        i_origin_z,
    input logic [rsi_pkg::CW-1:0]        i_dir_x,
    input logic [rsi_pkg::CW-1:0]        i_dir_y,
    input logic [rsi_pkg::CW-1:0]        i_dir_z,
    input logic [rsi_pkg::CW-1:0]        i_center_x,
    input logic [rsi_pkg::CW-1:0]        i_center_y,
    input logic [rsi_pkg::CW-1:0]        i_center_z,
    input logic [rsi_pkg::TW-1:0]        i_radius,
    input logic [rsi_pkg::TW-1:0]        i_t_end,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [rsi_pkg::TW-1:0]        i_cfg_t_start,
    input logic                          o_result_strobe,
    input logic [1:0]                    o_hit_kind,
    input logic [rsi_pkg::TW-1:0]        o_hit_time
);

    // A result only ever follows an accepted transfer.
    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(start && !busy, rsi_pkg::LATENCY))
        else $error("result strobe without an accepted transfer");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_hit_kind == rsi_pkg::HIT_NONE ||
                             o_hit_kind == rsi_pkg::HIT_ENTER ||
                             o_hit_kind == rsi_pkg::HIT_LEAVE))
        else $error("illegal hit kind");

    a_miss_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_hit_kind == rsi_pkg::HIT_NONE) |-> (o_hit_time == '0))
        else $error("no-hit result carries a time");

    a_hit_inside_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_hit_kind != rsi_pkg::HIT_NONE)
            |-> (o_hit_time <= $past(i_t_end, rsi_pkg::LATENCY)))
        else $error("hit time beyond the item's upper bound");

endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (.*);

[dv/ray_sphere_intersect_checker.sv]
// Hit predictor and result checker for the ray/sphere intersection unit.
`timescale 1ns / 1ps

module ray_sphere_intersect_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [rsi_pkg::CW-1:0] i_origin_x,
    input  logic signed [rsi_pkg::CW-1:0] i_origin_y,
    input  logic signed [rsi_pkg::CW-1:0] i_origin_z,
    input  logic signed [rsi_pkg::CW-1:0] i_dir_x,
    input  logic signed [rsi_pkg::CW-1:0] i_dir_y,
    input  logic signed [rsi_pkg::CW-1:0] i_dir_z,
    input  logic signed [rsi_pkg::CW-1:0] i_center_x,
    input  logic signed [rsi_pkg::CW-1:0] i_center_y,
    input  logic signed [rsi_pkg::CW-1:0] i_center_z,
    input  logic [rsi_pkg::TW-1:0]        i_radius,
    input  logic [rsi_pkg::TW-1:0]        i_t_end,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [rsi_pkg::TW-1:0]        i_cfg_t_start,
    input  logic                          i_result_strobe,
    input  logic [1:0]                    i_hit_kind,
    input  logic [rsi_pkg::TW-1:0]        i_hit_time,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int CW   = rsi_pkg::CW;
    localparam int TW   = rsi_pkg::TW;
    localparam int WIDE = 200;
    localparam logic [TW-1:0] TIME_MAX = '1;

    typedef logic signed [WIDE-1:0] t_wide;

    typedef struct packed {
        logic [1:0]    kind;
        logic [TW-1:0] t;
    } t_hit;

    t_hit          hit_q[$];
    logic [TW-1:0] t_start_copy;

    function automatic t_wide int_sqrt(input t_wide v);
        t_wide rem;
        t_wide res;
        t_wide bitv;
        rem  = v;
        res  = '0;
        bitv = t_wide'(1) <<< (WIDE - 2);
        while (bitv > rem) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    // Root time floor(n * 2^F / a), saturated; negative numerators give -1.
    function automatic t_wide root_time(input t_wide n, input t_wide a);
        t_wide q;
        if (n < 0) return -1;
        q = (n <<< rsi_pkg::FRAC_BITS_DEF) / a;
        if (q > t_wide'(TIME_MAX)) q = t_wide'(TIME_MAX);
        return q;
    endfunction

    function automatic t_hit predict_hit(
        input logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
        input logic [TW-1:0] rad, tend, tstart
    );
        t_wide px, py, pz, wdx, wdy, wdz, a, h, c, disc, s, t1, t2, r;
        t_hit res;
        wdx = t_wide'(dx);
        wdy = t_wide'(dy);
        wdz = t_wide'(dz);
        px  = t_wide'(ox) - t_wide'(cx);
        py  = t_wide'(oy) - t_wide'(cy);
        pz  = t_wide'(oz) - t_wide'(cz);
        r   = t_wide'({1'b0, rad});
        a   = wdx * wdx + wdy * wdy + wdz * wdz;
        h   = wdx * px + wdy * py + wdz * pz;
        c   = px * px + py * py + pz * pz - r * r;
        disc = h * h - a * c;
        res.kind = rsi_pkg::HIT_NONE;
        res.t    = '0;
        if (a == 0 || disc <= 0) return res;
        s  = int_sqrt(disc);
        t1 = root_time(-h - s, a);
        t2 = root_time(-h + s, a);
        if (t1 >= 0 && t1 >= t_wide'({1'b0, tstart}) && t1 <= t_wide'({1'b0, tend})) begin
            res.kind = rsi_pkg::HIT_ENTER;
            res.t    = t1[TW-1:0];
        end else if (t2 >= 0 && t2 >= t_wide'({1'b0, tstart})
                     && t2 <= t_wide'({1'b0, tend})) begin
            res.kind = rsi_pkg::HIT_LEAVE;
            res.t    = t2[TW-1:0];
        end
        return res;
    endfunction

    assign o_pending = hit_q.size();

    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            t_start_copy <= rsi_pkg::T_START_RST;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) t_start_copy <= i_cfg_t_start;
            if (start && !busy)
                hit_q.push_back(predict_hit(i_origin_x, i_origin_y, i_origin_z,
                                            i_dir_x, i_dir_y, i_dir_z,
                                            i_center_x, i_center_y, i_center_z,
                                            i_radius, i_t_end, t_start_copy));
            if (i_result_strobe) begin
                if (hit_q.size() == 0) begin
                    $display("%0t: result with nothing expected: kind %0d time %0d",
                             $time, i_hit_kind, i_hit_time);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = hit_q.pop_front();
                    if (want.kind !== i_hit_kind || want.t !== i_hit_time) begin
                        $display("%0t: hit mismatch: expected kind %0d time %0d,",
                                 $time, want.kind, want.t,
                                 " got kind %0d time %0d", i_hit_kind, i_hit_time);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[dv/ray_sphere_intersect_unit_tb.sv]
// Testbench top of the ray/sphere intersection unit: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module ray_sphere_intersect_unit_tb;

    localparam int CW = rsi_pkg::CW;
    localparam int TW = rsi_pkg::TW;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 320;
    localparam logic [TW-1:0] TIME_MAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [CW-1:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic signed [CW-1:0] i_center_x = '0, i_center_y = '0, i_center_z = '0;
    logic [TW-1:0] i_radius = '0;
    logic [TW-1:0] i_t_end = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [TW-1:0] i_cfg_t_start = '0;
    logic o_result_strobe;
    logic [1:0] o_hit_kind;
    logic [TW-1:0] o_hit_time;
    int fail_count;
    int pending;
    int quiet_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ray_sphere_intersect_unit dut (.*);

    ray_sphere_intersect_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy,
        .i_origin_x, .i_origin_y, .i_origin_z,
        .i_dir_x, .i_dir_y, .i_dir_z,
        .i_center_x, .i_center_y, .i_center_z,
        .i_radius, .i_t_end,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_t_start,
        .i_result_strobe(o_result_strobe), .i_hit_kind(o_hit_kind),
        .i_hit_time(o_hit_time),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The watchdog restarts on any transfer: an accepted ray, a result or a
    // register write. A long silence means the block has hung.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one ray and holds it until the block has taken it. The task
    // returns in the time step of the accepting edge.
    task automatic send_ray(
        input logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
        input logic [TW-1:0] rad, tend
    );
        i_origin_x <= ox; i_origin_y <= oy; i_origin_z <= oz;
        i_dir_x    <= dx; i_dir_y    <= dy; i_dir_z    <= dz;
        i_center_x <= cx; i_center_y <= cy; i_center_z <= cz;
        i_radius   <= rad;
        i_t_end    <= tend;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Each cycle the sender stays quiet with the given chance in a hundred.
    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // The register is written only once the pipeline has emptied.
    task automatic write_t_start(input logic [TW-1:0] value);
        drain_results();
        i_cfg_valid   <= 1'b1;
        i_cfg_t_start <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // A coordinate of moderate size, so that most rays meet spheres in view.
    function automatic logic signed [CW-1:0] near_coord();
        int sh;
        sh = $urandom_range(8, 22);
        return $signed($urandom_range(0, (1 << sh) - 1)) - $signed(1 << (sh - 1));
    endfunction

    function automatic logic [TW-1:0] pick_t_end();
        case ($urandom_range(3))
            0: return TIME_MAX;
            1: return $urandom() & TIME_MAX;
            default: return $urandom_range(0, 1 << 24);
        endcase
    endfunction

    task automatic send_random_ray;
        logic signed [CW-1:0] ox, oy, oz, cx, cy, cz;
        logic [TW-1:0] rad;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            // Aimed ray: direction points roughly at the centre, sometimes
            // from inside the sphere so that only the leaving root is ahead.
            cx = near_coord(); cy = near_coord(); cz = near_coord();
            rad = $urandom_range(1, 1 << $urandom_range(4, 22));
            if ($urandom_range(2) == 0) begin
                ox = cx + (near_coord() >>> 4);
                oy = cy + (near_coord() >>> 4);
                oz = cz + (near_coord() >>> 4);
            end else begin
                ox = near_coord(); oy = near_coord(); oz = near_coord();
            end
            send_ray(ox, oy, oz,
                     (cx - ox) + (near_coord() >>> 6), (cy - oy) + (near_coord() >>> 6),
                     (cz - oz) + (near_coord() >>> 6), cx, cy, cz, rad, pick_t_end());
        end else if (pick < 85) begin
            // Raw noise across every bit of every field.
            send_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom() & TIME_MAX, $urandom() & TIME_MAX);
        end else if (pick < 93) begin
            // Tangent ray grazing the sphere at exactly one point.
            rad = $urandom_range(1, 1 << 20);
            send_ray(-$signed($urandom_range(1, 1 << 22)), rad, 0,
                     $urandom_range(1, 1 << 18), 0, 0, 0, 0, 0, rad, TIME_MAX);
        end else begin
            // Zero direction vector.
            send_ray(near_coord(), near_coord(), near_coord(), 0, 0, 0,
                     near_coord(), near_coord(), near_coord(),
                     $urandom_range(1, 1 << 20), TIME_MAX);
        end
    endtask

    task automatic send_directed_rays;
        localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;
        localparam logic signed [CW-1:0] SMAX = 32'sh7fff_ffff;
        localparam logic signed [CW-1:0] SMIN = 32'sh8000_0000;
        // Unit sphere at five along x, ray from the origin along +x.
        send_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, TIME_MAX);
        // The same ray starting inside the sphere: leaving hit.
        send_ray(5 * ONE, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, TIME_MAX);
        // Sphere behind the ray.
        send_ray(0, 0, 0, -ONE, 0, 0, 5 * ONE, 0, 0, ONE, TIME_MAX);
        // t_end cuts off both roots: first below the near one, then at time zero.
        send_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, 3 * ONE);
        send_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, 0);
        // Tangent: the ray grazes the top of the sphere.
        send_ray(0, ONE, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, TIME_MAX);
        // Clear miss.
        send_ray(0, 3 * ONE, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, TIME_MAX);
        // Zero direction.
        send_ray(0, 0, 0, 0, 0, 0, 5 * ONE, 0, 0, ONE, TIME_MAX);
        // Tiny direction towards a far sphere: saturated times.
        send_ray(0, 0, 0, 1, 0, 0, SMAX, 0, 0, 1 << 20, TIME_MAX);
        send_ray(0, 0, 0, 1, 0, 0, SMAX, 0, 0, 1 << 20, TIME_MAX - 1);
        // Extremes of every field.
        send_ray(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, TIME_MAX, TIME_MAX);
        send_ray(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, TIME_MAX, TIME_MAX);
        send_ray(SMIN, SMAX, SMIN, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 0, TIME_MAX);
        send_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, TIME_MAX, TIME_MAX);
        send_ray(0, 0, 0, SMIN, 0, 0, 0, 0, 0, TIME_MAX, TIME_MAX);
        send_ray(0, 0, 0, 0, 0, SMAX, 0, 0, 0, 0, 0);
        // Sphere of radius zero on the ray.
        send_ray(0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0, 0, TIME_MAX);
        // Origin on the surface: the near root is time zero.
        send_ray(4 * ONE, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE, TIME_MAX);
    endtask

    initial begin
        int idle_pct[6];
        logic [TW-1:0] t_start_val[6];
        idle_pct    = '{0, 61, 0, 38, 61, 0};
        t_start_val = '{rsi_pkg::T_START_RST, '0, TIME_MAX, TW'(32'h0001_0000),
                        $urandom() & TIME_MAX, rsi_pkg::T_START_RST};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed_rays();
        // Let the whole pipeline empty before anything else is sent.
        drain_results();

        // The first phase runs on the reset value of t_start; each later phase
        // writes a new lower bound, the extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) write_t_start(t_start_val[ph]);
            if (ph == 2 || ph == 4) begin
                // Under the largest t_start and under a random one, the directed set
                // is repeated with the new bound.
                send_directed_rays();
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random_ray();
                sender_gap(idle_pct[ph]);
            end
        end

        drain_results();
        repeat (rsi_pkg::LATENCY + 10) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
